/* rtl/lru_frame_replacer_defines.svh */
// ----------------------------------------------------------------------------
// lru_frame_replacer_defines.svh
// Assertion macros shared by the frame replacer RTL.
// Each macro expects a clock named clock and a reset named reset in scope.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_DEFINES_SVH
`define LRU_FRAME_REPLACER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset
`define LFR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfr assertion failed");

// Invariant that must hold on every rising edge outside reset
`define LFR_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lfr invariant failed");

`else

`define LFR_ASSERT_NOW(lbl, ante, cons)
`define LFR_ASSERT_ALWAYS(lbl, cond)

`endif

`endif

/* rtl/lfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared codes, default sizes and reset values of the LRU frame replacer.
// ----------------------------------------------------------------------------
package lfr_pkg;

   // default sizes
   localparam int FRAME_COUNT_DEF = 64;
   localparam int STAMP_BITS_DEF  = 32;

   // fixed field widths
   localparam int OPCODE_W = 2;
   localparam int FRAME_W  = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // reset value of the active frame register
   localparam logic [COUNT_W-1:0] ACTIVE_FRAMES_RST = 7'd64;

   // request operations
   localparam logic [OPCODE_W-1:0] OP_ACCESS  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_EVT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_EVICT   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STS_PINNED    = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NO_VICTIM = 2'd3;

endpackage

/* rtl/lru_frame_replacer.sv */
`timescale 1ns / 1ps
// Access, set-evictable and remove read the entry from ST_IDLE, modify it in ST_ACCESS
//   and strobe rsp_valid from a register; busy stays high until the block is back in ST_IDLE.
// Out-of-range requests are answered from ST_IDLE. Evict reads one entry a cycle from the
//   entry RAM and stays busy until the victim is reported.
// After reset, busy stays high while the entry RAM is cleared.
// Results cannot be stalled by the receiver; the CSR port is always ready.
// ----------------------------------------------------------------------------
// lru_frame_replacer
// LRU frame replacer with pinning: per-frame state and stamps live in one RAM,
// updated by read-modify-write; evict scans the RAM for the oldest stamp.
// ----------------------------------------------------------------------------
`include "lru_frame_replacer_defines.svh"

module lru_frame_replacer #(
   parameter int FRAME_COUNT = lfr_pkg::FRAME_COUNT_DEF,
   parameter int STAMP_BITS  = lfr_pkg::STAMP_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [lfr_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [lfr_pkg::FRAME_W-1:0]    req_frame_index,
   input  logic                           req_make_evictable,
   // response channel
   output logic                           rsp_valid,
   output logic [lfr_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_victim_valid,
   output logic [lfr_pkg::FRAME_W-1:0]    rsp_victim_frame,
   output logic [lfr_pkg::COUNT_W-1:0]    rsp_evictable_count,
   // configuration channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lfr_pkg::COUNT_W-1:0]    csr_wdata
);

   localparam int IDX_W   = $clog2(FRAME_COUNT);
   localparam int ENTRY_W = STAMP_BITS + 2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
   localparam logic [lfr_pkg::COUNT_W-1:0] COUNT_MAX = 7'd64;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_EVICT
   } state_type;

   state_type                      state_ff, state_in;
   logic [IDX_W-1:0]               scan_ff, scan_in;
   logic [lfr_pkg::OPCODE_W-1:0]   op_ff, op_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           unpin_ff, unpin_in;
   logic [STAMP_BITS-1:0]          clock_ff, clock_in;
   logic [lfr_pkg::COUNT_W-1:0]    total_ff, total_in;
   logic [lfr_pkg::COUNT_W-1:0]    active_ff, active_in;
   logic                           found_ff, found_in;
   logic [STAMP_BITS-1:0]          best_ff, best_in;
   logic [IDX_W-1:0]               best_idx_ff, best_idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lfr_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                           rsp_vvalid_ff, rsp_vvalid_in;
   logic [lfr_pkg::FRAME_W-1:0]    rsp_vframe_ff, rsp_vframe_in;
   logic [lfr_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  ram_en;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_addr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic [ENTRY_W-1:0]    ram_rdata;

   logic                  rd_tracked;
   logic                  rd_evict;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic                  index_ok;
   logic [STAMP_BITS-1:0] clock_next;
   logic                  take;

   // entry RAM: {tracked, evictable, stamp}
   lfr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FRAME_COUNT)
   ) u_entry_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_tracked = ram_rdata[ENTRY_W-1];
   assign rd_evict   = ram_rdata[ENTRY_W-2];
   assign rd_stamp   = ram_rdata[STAMP_BITS-1:0];

   // range check of the incoming frame index
   assign index_ok = (req_frame_index < 6'(active_ff) || active_ff > 7'd63)
                     && (32'(req_frame_index) < 32'(FRAME_COUNT))
                     && ({1'b0, req_frame_index} < active_ff);

   // saturating access clock
   assign clock_next = (clock_ff == STAMP_MAX) ? clock_ff : clock_ff + 1'b1;

   // scan compare: oldest stamp wins, ties keep the lower index
   assign take = rd_tracked && rd_evict && (!found_ff || (rd_stamp < best_ff));

   // next-state and RAM control
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      unpin_in      = unpin_ff;
      clock_in      = clock_ff;
      total_in      = total_ff;
      active_in     = active_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_vframe_in = rsp_vframe_ff;
      rsp_count_in  = rsp_count_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = scan_ff;
      ram_wdata     = '0;

      // take a configuration write
      if (csr_valid) begin
         active_in = csr_wdata;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // wipe one entry a cycle
            ram_en = 1'b1;
            ram_we = 1'b1;
            if (scan_ff == LAST_IDX) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               idx_in   = IDX_W'(req_frame_index);
               unpin_in = req_make_evictable;
               if (req_opcode == lfr_pkg::OP_EVICT) begin
                  // launch the scan at entry zero
                  ram_en   = 1'b1;
                  ram_addr = '0;
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (!index_ok) begin
                  // reject at once, nothing changes
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lfr_pkg::STS_RANGE;
                  rsp_vvalid_in = 1'b0;
                  rsp_vframe_in = '0;
                  rsp_count_in  = total_ff;
               end else begin
                  ram_en   = 1'b1;
                  ram_addr = IDX_W'(req_frame_index);
                  state_in = ST_ACCESS;
               end
            end
         end

         ST_ACCESS: begin
            // modify the entry read last cycle and write it back when the operation changes it
            ram_addr      = idx_ff;
            rsp_status_in = lfr_pkg::STS_OK;
            unique case (op_ff)
               lfr_pkg::OP_ACCESS: begin
                  clock_in  = clock_next;
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = {1'b1, rd_tracked & rd_evict, clock_next};
               end
               lfr_pkg::OP_SET_EVT: begin
                  if (rd_tracked) begin
                     if (rd_evict && !unpin_ff) begin
                        total_in = total_ff - 1'b1;
                     end else if (!rd_evict && unpin_ff) begin
                        total_in = total_ff + 1'b1;
                     end
                     ram_en    = 1'b1;
                     ram_we    = 1'b1;
                     ram_wdata = {1'b1, unpin_ff, rd_stamp};
                  end
               end
               lfr_pkg::OP_REMOVE: begin
                  if (rd_tracked) begin
                     if (!rd_evict) begin
                        rsp_status_in = lfr_pkg::STS_PINNED;
                     end else begin
                        total_in  = total_ff - 1'b1;
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = {2'b00, rd_stamp};
                     end
                  end
               end
               default: begin
               end
            endcase
            rsp_valid_in  = 1'b1;
            rsp_vvalid_in = 1'b0;
            rsp_vframe_in = '0;
            rsp_count_in  = total_in;
            state_in      = ST_IDLE;
         end

         ST_SCAN: begin
            // compare the entry in hand, fetch the next one until the last
            if (take) begin
               found_in    = 1'b1;
               best_in     = rd_stamp;
               best_idx_in = scan_ff;
            end
            if (scan_ff == LAST_IDX) begin
               state_in = ST_EVICT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               ram_en   = 1'b1;
               ram_addr = scan_ff + 1'b1;
            end
         end

         ST_EVICT: begin
            // drop the victim and report it
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               ram_en        = 1'b1;
               ram_we        = 1'b1;
               ram_addr      = best_idx_ff;
               ram_wdata     = {2'b00, best_ff};
               total_in      = (total_ff != '0) ? total_ff - 1'b1 : total_ff;
               rsp_status_in = lfr_pkg::STS_OK;
               rsp_vvalid_in = 1'b1;
               rsp_vframe_in = lfr_pkg::FRAME_W'(best_idx_ff);
            end else begin
               rsp_status_in = lfr_pkg::STS_NO_VICTIM;
               rsp_vvalid_in = 1'b0;
               rsp_vframe_in = '0;
            end
            rsp_count_in = total_in;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         clock_ff     <= '0;
         total_ff     <= '0;
         active_ff    <= lfr_pkg::ACTIVE_FRAMES_RST;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         clock_ff     <= clock_in;
         total_ff     <= total_in;
         active_ff    <= active_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      unpin_ff      <= unpin_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_vframe_ff <= rsp_vframe_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_victim_valid    = rsp_vvalid_ff;
   assign rsp_victim_frame    = rsp_vframe_ff;
   assign rsp_evictable_count = rsp_count_ff;

   // checks
   `LFR_ASSERT_ALWAYS(a_total_bound, total_ff <= COUNT_MAX)
   `LFR_ASSERT_NOW(a_victim_ok, rsp_valid_ff && rsp_vvalid_ff, rsp_status_ff == lfr_pkg::STS_OK)
   `LFR_ASSERT_NOW(a_scan_no_write, state_ff == ST_SCAN, !ram_we)
   `LFR_ASSERT_NOW(a_clock_mono, !$past(reset), clock_ff >= $past(clock_ff))

endmodule

/* rtl/lfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfr_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write when enabled with we set, otherwise register the read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* tb/tb_lru_frame_replacer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer
// Self-checking bench for the LRU frame replacer. A directed opening covers
// the empty evict, untracked, pinned and out-of-range requests and the evict
// scope above a lowered frame limit. Random phases follow, each under its own
// active frame limit. A built-in replacer model predicts every response and
// the monitor compares each strobed response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_lru_frame_replacer;

   localparam int NFRAMES     = lfr_pkg::FRAME_COUNT_DEF;
   localparam int STAMP_W     = lfr_pkg::STAMP_BITS_DEF;
   localparam int OPC_W       = lfr_pkg::OPCODE_W;
   localparam int FRM_W       = lfr_pkg::FRAME_W;
   localparam int STS_W       = lfr_pkg::STATUS_W;
   localparam int CNT_W       = lfr_pkg::COUNT_W;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [OPC_W-1:0] opcode;
      logic [FRM_W-1:0] frame;
      logic             unpin;
   } frame_req_type;

   typedef struct packed {
      logic [STS_W-1:0] status;
      logic             victim_valid;
      logic [FRM_W-1:0] victim_frame;
      logic [CNT_W-1:0] evictable_count;
   } frame_rsp_type;

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             start              = 1'b0;
   logic             busy;
   logic [OPC_W-1:0] req_opcode         = '0;
   logic [FRM_W-1:0] req_frame_index    = '0;
   logic             req_make_evictable = 1'b0;
   logic             rsp_valid;
   logic [STS_W-1:0] rsp_status;
   logic             rsp_victim_valid;
   logic [FRM_W-1:0] rsp_victim_frame;
   logic [CNT_W-1:0] rsp_evictable_count;
   logic             csr_valid          = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_wdata          = '0;

   lru_frame_replacer u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_frame_index     (req_frame_index),
      .req_make_evictable  (req_make_evictable),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_victim_valid    (rsp_victim_valid),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_evictable_count (rsp_evictable_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state of the replacer
   logic               model_tracked   [NFRAMES];
   logic               model_evictable [NFRAMES];
   logic [STAMP_W-1:0] model_stamp     [NFRAMES];
   logic [STAMP_W-1:0] model_clock     = '0;
   logic [CNT_W-1:0]   model_evt_total = '0;
   logic [CNT_W-1:0]   active_limit    = lfr_pkg::ACTIVE_FRAMES_RST;

   frame_req_type pending_reqs[$];
   frame_rsp_type expected_rsps[$];
   int unsigned   csr_writes   = 0;
   int unsigned   errors       = 0;
   int unsigned   stall_cycles = 0;
   logic          req_taken    = 1'b0;
   int unsigned   gap_max      = 0;

   initial begin
      for (int i = 0; i < NFRAMES; i++) begin
         model_tracked[i]   = 1'b0;
         model_evictable[i] = 1'b0;
         model_stamp[i]     = '0;
      end
   end

   // apply one request to the model and return the response it produces
   function automatic frame_rsp_type replace_outcome(frame_req_type r);
      frame_rsp_type      o;
      logic               found;
      logic [STAMP_W-1:0] oldest;
      int                 pick;
      o      = '0;
      found  = 1'b0;
      oldest = '0;
      pick   = 0;
      o.status = lfr_pkg::STS_OK;
      if (r.opcode != lfr_pkg::OP_EVICT && {1'b0, r.frame} >= active_limit) begin
         o.status = lfr_pkg::STS_RANGE;
      end else begin
         case (r.opcode)
            lfr_pkg::OP_ACCESS: begin
               // saturate the access clock, pin on first touch
               if (model_clock != '1) model_clock++;
               if (!model_tracked[r.frame]) begin
                  model_tracked[r.frame]   = 1'b1;
                  model_evictable[r.frame] = 1'b0;
               end
               model_stamp[r.frame] = model_clock;
            end
            lfr_pkg::OP_SET_EVT: begin
               if (model_tracked[r.frame]) begin
                  if (model_evictable[r.frame] && !r.unpin) model_evt_total--;
                  else if (!model_evictable[r.frame] && r.unpin) model_evt_total++;
                  model_evictable[r.frame] = r.unpin;
               end
            end
            lfr_pkg::OP_REMOVE: begin
               if (model_tracked[r.frame]) begin
                  if (!model_evictable[r.frame]) begin
                     o.status = lfr_pkg::STS_PINNED;
                  end else begin
                     model_tracked[r.frame]   = 1'b0;
                     model_evictable[r.frame] = 1'b0;
                     model_evt_total--;
                  end
               end
            end
            default: begin
               // oldest stamp wins, lowest index on a tie
               for (int i = 0; i < NFRAMES; i++) begin
                  if (model_tracked[i] && model_evictable[i] &&
                      (!found || model_stamp[i] < oldest)) begin
                     found  = 1'b1;
                     oldest = model_stamp[i];
                     pick   = i;
                  end
               end
               if (!found) begin
                  o.status = lfr_pkg::STS_NO_VICTIM;
               end else begin
                  model_tracked[pick]   = 1'b0;
                  model_evictable[pick] = 1'b0;
                  if (model_evt_total != 0) model_evt_total--;
                  o.victim_valid = 1'b1;
                  o.victim_frame = FRM_W'(pick);
               end
            end
         endcase
      end
      o.evictable_count = model_evt_total;
      return o;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // sample responses, predict accepted requests, track CSR writes, watchdog
   always @(posedge clock) begin : monitor
      frame_rsp_type want;
      frame_req_type taken;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         stall_cycles++;
         if (rsp_valid) begin
            stall_cycles = 0;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: status %0d victim %0d/%0d count %0d",
                        $time, rsp_status, rsp_victim_valid, rsp_victim_frame,
                        rsp_evictable_count);
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("victim_valid", 8'(want.victim_valid), 8'(rsp_victim_valid));
               check_field("victim_frame", 8'(want.victim_frame), 8'(rsp_victim_frame));
               check_field("evictable_count", 8'(want.evictable_count),
                           8'(rsp_evictable_count));
            end
         end
         req_taken = start && !busy;
         if (req_taken) begin
            stall_cycles = 0;
            taken = '{opcode: req_opcode, frame: req_frame_index, unpin: req_make_evictable};
            expected_rsps.push_back(replace_outcome(taken));
         end
         if (csr_valid && csr_ready) begin
            stall_cycles = 0;
            active_limit = csr_wdata;
            csr_writes++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $time, expected_rsps.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // present requests in bursts with random gaps; hold each until taken
   always @(negedge clock) begin : driver
      frame_req_type nxt;
      logic          go;
      int            gap_left;
      int            burst_left;
      nxt.opcode = OPC_W'($urandom_range(0, 3));
      nxt.frame  = FRM_W'($urandom_range(0, 63));
      nxt.unpin  = 1'($urandom_range(0, 1));
      go         = 1'b0;
      if (!reset && (!start || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            go  = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
            end else begin
               burst_left--;
            end
         end
         start              <= go;
         req_opcode         <= nxt.opcode;
         req_frame_index    <= nxt.frame;
         req_make_evictable <= nxt.unpin;
      end
   end

   task automatic queue_req(logic [OPC_W-1:0] op, int frame, logic unpin);
      pending_reqs.push_back('{opcode: op, frame: FRM_W'(frame), unpin: unpin});
   endtask

   // hold off until every queued request is answered
   task automatic drain();
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_active(logic [CNT_W-1:0] limit);
      int unsigned n;
      n = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= limit;
      wait (csr_writes != n);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_wdata <= CNT_W'($urandom);
   endtask

   // random traffic on a small frame pool so requests hit tracked frames
   task automatic queue_random(int n);
      int lim;
      int pool_n;
      int pool_lo;
      int pct;
      int frame;
      logic [OPC_W-1:0] op;
      lim = (active_limit == 0) ? 1 : ((active_limit > NFRAMES) ? NFRAMES : active_limit);
      for (int k = 0; k < n; k++) begin
         if (k % 40 == 0) begin
            pool_n  = $urandom_range(1, (lim < 8) ? lim : 8);
            pool_lo = $urandom_range(0, lim - pool_n);
         end
         pct = $urandom_range(0, 99);
         if (pct < 35)      op = lfr_pkg::OP_ACCESS;
         else if (pct < 65) op = lfr_pkg::OP_SET_EVT;
         else if (pct < 78) op = lfr_pkg::OP_REMOVE;
         else               op = lfr_pkg::OP_EVICT;
         if (op == lfr_pkg::OP_EVICT || $urandom_range(0, 9) == 0)
            frame = $urandom_range(0, 63);
         else
            frame = pool_lo + $urandom_range(0, pool_n - 1);
         queue_req(op, frame, ($urandom_range(0, 3) != 0));
      end
   endtask

   initial begin : stimulus
      logic [CNT_W-1:0] limits [9];
      int unsigned      gaps   [9];
      limits = '{7'd127, 7'd2, 7'd17, 7'd64, 7'd1, 7'd40, 7'd33, 7'd0, 7'd64};
      gaps   = '{0, 8, 3, 12, 0, 5, 2, 6, 0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty evict, untracked frames, pinned remove, LRU order
      gap_max = 3;
      queue_req(lfr_pkg::OP_EVICT, 0, 1'b0);
      queue_req(lfr_pkg::OP_SET_EVT, 5, 1'b1);
      queue_req(lfr_pkg::OP_REMOVE, 5, 1'b0);
      queue_req(lfr_pkg::OP_ACCESS, 0, 1'b0);
      queue_req(lfr_pkg::OP_ACCESS, 63, 1'b1);
      queue_req(lfr_pkg::OP_ACCESS, 5, 1'b0);
      queue_req(lfr_pkg::OP_ACCESS, 40, 1'b0);
      queue_req(lfr_pkg::OP_REMOVE, 5, 1'b0);
      queue_req(lfr_pkg::OP_SET_EVT, 5, 1'b1);
      queue_req(lfr_pkg::OP_SET_EVT, 63, 1'b1);
      queue_req(lfr_pkg::OP_SET_EVT, 0, 1'b1);
      queue_req(lfr_pkg::OP_SET_EVT, 0, 1'b1);
      queue_req(lfr_pkg::OP_SET_EVT, 0, 1'b0);
      queue_req(lfr_pkg::OP_ACCESS, 63, 1'b0);
      queue_req(lfr_pkg::OP_EVICT, 42, 1'b1);
      queue_req(lfr_pkg::OP_EVICT, 21, 1'b0);
      queue_req(lfr_pkg::OP_EVICT, 63, 1'b1);
      queue_req(lfr_pkg::OP_SET_EVT, 0, 1'b1);
      queue_req(lfr_pkg::OP_REMOVE, 0, 1'b0);
      queue_req(lfr_pkg::OP_REMOVE, 0, 1'b0);
      queue_req(lfr_pkg::OP_SET_EVT, 40, 1'b1);
      drain();

      // one active frame: out-of-range requests, evict beyond the limit
      write_active(7'd1);
      queue_req(lfr_pkg::OP_ACCESS, 1, 1'b1);
      queue_req(lfr_pkg::OP_SET_EVT, 63, 1'b1);
      queue_req(lfr_pkg::OP_REMOVE, 1, 1'b0);
      queue_req(lfr_pkg::OP_ACCESS, 0, 1'b0);
      queue_req(lfr_pkg::OP_EVICT, 0, 1'b0);
      queue_req(lfr_pkg::OP_REMOVE, 0, 1'b0);
      queue_req(lfr_pkg::OP_EVICT, 0, 1'b0);
      drain();

      // no active frames: every indexed request is rejected
      write_active(7'd0);
      queue_req(lfr_pkg::OP_ACCESS, 0, 1'b0);
      queue_req(lfr_pkg::OP_SET_EVT, 0, 1'b1);
      queue_req(lfr_pkg::OP_REMOVE, 0, 1'b0);
      queue_req(lfr_pkg::OP_EVICT, 0, 1'b0);
      drain();

      // random phases, one frame limit each, quiet between them
      for (int p = 0; p < 9; p++) begin
         write_active(limits[p]);
         gap_max = gaps[p];
         queue_random((limits[p] == 0) ? 40 : 175);
         drain();
      end

      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
